// ----- src/fixed_block_pool_allocator_core_defines.svh -----
// assertion macros for the block pool allocator checker
// no dependencies
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH

// checked only while out of reset
`define FBPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbpa assertion failed");

// checked at every edge, reset included
`define FBPA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("fbpa assertion failed");

`endif

// ----- src/fbpa_pkg.sv -----
// shared types, constants and helpers of the block pool allocator
// no dependencies
package fbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = 10;
    localparam int LINK_W     = 11;
    localparam int ENTRY_W    = LINK_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [LINK_W-1:0] NIL     = LINK_W'(MAX_BLOCKS);
    localparam logic [LINK_W-1:0] MAX_CAP = LINK_W'(MAX_BLOCKS);

    localparam logic [CFG_IDX_W-1:0] CFG_START_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_ON_FULL = 2'd1;

    localparam logic [CFG_DATA_W-1:0] START_BLOCKS_RST = 11'd64;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_CLAIM   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_BAD_REL   = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [IDX_W-1:0] block_index;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  granted_index;
        logic              was_free;
        logic [LINK_W-1:0] in_use_count;
        logic [LINK_W-1:0] capacity;
    } t_out;

    // entry layout: {in_use, next_link}
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

    function automatic logic [LINK_W-1:0] clamp_start(input logic [CFG_DATA_W-1:0] v);
        logic [LINK_W-1:0] r;
        if (v == '0) begin
            r = LINK_W'(1);
        end else if (v > MAX_CAP) begin
            r = MAX_CAP;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- src/fbpa_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/fbpa_seq.sv -----
// sequencer: sweeps, list pops/pushes and the unlink walk over the entry ram
// depends on fbpa_pkg
module fbpa_seq import fbpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in                   i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_mem_req              o_mem,
    input  logic [ENTRY_W-1:0]    i_rdata,
    output logic                  o_res_valid,
    output t_out                  o_res,
    input  logic                  i_res_take
);

    typedef enum logic [6:0] {
        S_SWEEP = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ISSUE = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_FIX   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]        r_func, n_func;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_grow, n_grow;
    logic [LINK_W-1:0] r_size, n_size;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_used, n_used;
    logic [LINK_W-1:0] r_sw, n_sw;
    logic [LINK_W-1:0] r_sw_end, n_sw_end;
    logic              r_sw_grow, n_sw_grow;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [LINK_W-1:0] r_link, n_link;
    logic [1:0]        r_status, n_status;
    logic [IDX_W-1:0]  r_granted, n_granted;
    logic              r_was_free, n_was_free;

    logic [LINK_W:0]   sw_inc;
    logic [LINK_W:0]   grown;
    logic              rd_flag;
    logic [LINK_W-1:0] rd_link;

    assign sw_inc  = {1'b0, r_sw} + (LINK_W+1)'(1);
    assign grown   = {r_size, 1'b0};
    assign rd_flag = i_rdata[ENTRY_W-1];
    assign rd_link = i_rdata[LINK_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_idx      = r_idx;
        n_grow     = r_grow;
        n_size     = r_size;
        n_head     = r_head;
        n_used     = r_used;
        n_sw       = r_sw;
        n_sw_end   = r_sw_end;
        n_sw_grow  = r_sw_grow;
        n_cur      = r_cur;
        n_link     = r_link;
        n_status   = r_status;
        n_granted  = r_granted;
        n_was_free = r_was_free;
        o_mem      = '0;

        unique case (r_state)
            S_SWEEP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_sw[IDX_W-1:0];
                o_mem.wdata = {1'b0, (sw_inc < {1'b0, r_size}) ? sw_inc[LINK_W-1:0] : NIL};
                n_sw        = sw_inc[LINK_W-1:0];
                if (sw_inc == {1'b0, r_sw_end}) begin
                    if (r_sw_grow) begin
                        n_state = S_ISSUE;
                    end else begin
                        n_head  = '0;
                        n_used  = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func     = i_in_data.func;
                    n_idx      = i_in_data.block_index;
                    n_status   = ST_OK;
                    n_granted  = '0;
                    n_was_free = 1'b0;
                    n_state    = S_DONE;
                    case (i_in_data.func)
                        FUNC_ALLOC: begin
                            if (r_head != NIL) begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_head[IDX_W-1:0];
                                n_state     = S_RD;
                            end else if (r_grow && r_size < MAX_CAP) begin
                                // new blocks only, linked ascending from the old size
                                n_sw      = r_size;
                                n_head    = r_size;
                                n_size    = (grown > {1'b0, MAX_CAP}) ? MAX_CAP
                                                                      : grown[LINK_W-1:0];
                                n_sw_end  = n_size;
                                n_sw_grow = 1'b1;
                                n_state   = S_SWEEP;
                            end else begin
                                n_status = ST_EXHAUSTED;
                            end
                        end
                        FUNC_RELEASE, FUNC_CLAIM: begin
                            if ({1'b0, i_in_data.block_index} >= r_size) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = i_in_data.block_index;
                                n_state     = S_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_head[IDX_W-1:0];
                n_state     = S_RD;
            end
            S_RD: begin
                n_state = S_DONE;
                case (r_func)
                    FUNC_ALLOC: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_head[IDX_W-1:0];
                        o_mem.wdata = {1'b1, NIL};
                        n_head      = rd_link;
                        n_used      = r_used + LINK_W'(1);
                        n_granted   = r_head[IDX_W-1:0];
                        n_was_free  = 1'b1;
                    end
                    FUNC_RELEASE: begin
                        if (!rd_flag) begin
                            n_status = ST_BAD_REL;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_idx;
                            o_mem.wdata = {1'b0, r_head};
                            n_head      = {1'b0, r_idx};
                            if (r_used != '0) begin
                                n_used = r_used - LINK_W'(1);
                            end
                        end
                    end
                    FUNC_CLAIM: begin
                        n_granted = r_idx;
                        n_link    = rd_link;
                        if (!rd_flag) begin
                            if (r_head == {1'b0, r_idx}) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_idx;
                                o_mem.wdata = {1'b1, NIL};
                                n_head      = rd_link;
                                n_used      = r_used + LINK_W'(1);
                                n_was_free  = 1'b1;
                            end else begin
                                // walk from the head to find the predecessor
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_head[IDX_W-1:0];
                                n_cur       = r_head[IDX_W-1:0];
                                n_state     = S_WALK;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                if (rd_link == {1'b0, r_idx}) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_cur;
                    o_mem.wdata = {1'b0, r_link};
                    n_state     = S_FIX;
                end else if (rd_link == NIL) begin
                    n_state = S_FIX;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = rd_link[IDX_W-1:0];
                    n_cur       = rd_link[IDX_W-1:0];
                end
            end
            S_FIX: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = {1'b1, NIL};
                n_used      = r_used + LINK_W'(1);
                n_was_free  = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_BLOCKS: begin
                    n_size    = clamp_start(i_cfg_data);
                    n_sw      = '0;
                    n_sw_end  = MAX_CAP;
                    n_sw_grow = 1'b0;
                    n_state   = S_SWEEP;
                end
                CFG_GROW_ON_FULL: begin
                    n_grow = i_cfg_data[0];
                end
                default: begin
                    n_grow = r_grow;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_grow    <= 1'b0;
            r_size    <= clamp_start(START_BLOCKS_RST);
            r_head    <= '0;
            r_used    <= '0;
            r_sw      <= '0;
            r_sw_end  <= MAX_CAP;
            r_sw_grow <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_grow    <= n_grow;
            r_size    <= n_size;
            r_head    <= n_head;
            r_used    <= n_used;
            r_sw      <= n_sw;
            r_sw_end  <= n_sw_end;
            r_sw_grow <= n_sw_grow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_link     <= n_link;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_was_free <= n_was_free;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status        = r_status;
        o_res.granted_index = r_granted;
        o_res.was_free      = r_was_free;
        o_res.in_use_count  = r_used;
        o_res.capacity      = r_size;
    end

endmodule

// ----- src/fixed_block_pool_allocator_core.sv -----
// allocate, release and a claim of the block at the list head pass through the read state
// and the done state to the output register; a claim from the middle walks the list entry
// by entry, then fixes the entry; growth first sweeps in the new blocks, then issues the read
// throughput: one item in flight, next beat taken once the result reaches the output register
// reset and every start_blocks write run a pass over all 1024 ram entries (input stalled)
// reset: synchronous active-low, start_blocks 64, grow_on_full 0
module fixed_block_pool_allocator_core import fbpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_mem_req           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               res_valid;
    t_out               res;
    logic               res_take;
    logic               r_out_valid;
    t_out               r_out_data;

    fbpa_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    fbpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- src/fbpa_checker.sv -----
// port-level checks of the block pool allocator, bound to the top level
// depends on fbpa_pkg and fixed_block_pool_allocator_core_defines.svh
`include "fixed_block_pool_allocator_core_defines.svh"

module fbpa_checker import fbpa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    `FBPA_ASSERT_ALWAYS(a_stall_after_reset, i_clk, !i_rst_n |=> o_in_stall)

    `FBPA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))

    `FBPA_ASSERT(a_cap_range, i_clk, i_rst_n, o_out_valid |-> o_out_data.capacity != '0 && o_out_data.capacity <= MAX_CAP)

    `FBPA_ASSERT(a_used_le_cap, i_clk, i_rst_n, o_out_valid |-> o_out_data.in_use_count <= o_out_data.capacity)

    `FBPA_ASSERT(a_grant_in_pool, i_clk, i_rst_n, o_out_valid && o_out_data.was_free |-> o_out_data.status == ST_OK && {1'b0, o_out_data.granted_index} < o_out_data.capacity)

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);

// ----- bench/fixed_block_pool_allocator_core_tb.sv -----
// self-checking bench for the fixed block pool allocator core
// depends on fbpa_pkg and fixed_block_pool_allocator_core
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core_tb;
    import fbpa_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in                   in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fixed_block_pool_allocator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow pool state
    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic              used_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] head_blk;
    logic [LINK_W-1:0] n_used;
    logic [LINK_W-1:0] n_cap;
    logic [CFG_DATA_W-1:0] start_reg;
    logic              grow_reg;

    t_out   pending_q[$];
    int     n_errors = 0;
    longint cycle_cnt = 0;
    bit     quiet = 1'b0;
    int     stall_left = 0;

    task automatic rebuild_pool();
        logic [LINK_W-1:0] sz;
        sz = (start_reg == 0) ? LINK_W'(1) :
             (start_reg > MAX_BLOCKS) ? LINK_W'(MAX_BLOCKS) : LINK_W'(start_reg);
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            link_mem[i] = NIL;
            used_mem[i] = 1'b0;
        end
        for (int i = 0; i < sz; i++) begin
            link_mem[i] = (i + 1 < sz) ? LINK_W'(i + 1) : NIL;
        end
        head_blk = 0;
        n_used   = 0;
        n_cap    = sz;
    endtask

    function automatic t_out predict_op(t_in it);
        t_out r;
        logic [LINK_W-1:0] prv, cur, b, grown;
        int steps;
        r = '0;
        case (it.func)
            FUNC_ALLOC: begin
                if (head_blk == NIL && grow_reg && n_cap < MAX_BLOCKS) begin
                    grown = (n_cap * 2 > MAX_BLOCKS) ? LINK_W'(MAX_BLOCKS)
                                                     : LINK_W'(n_cap * 2);
                    for (int i = n_cap; i < grown; i++) begin
                        link_mem[i] = (i + 1 < grown) ? LINK_W'(i + 1) : NIL;
                    end
                    head_blk = n_cap;
                    n_cap = grown;
                end
                if (head_blk == NIL) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    b = head_blk;
                    head_blk = link_mem[b];
                    link_mem[b] = NIL;
                    used_mem[b] = 1'b1;
                    n_used++;
                    r.granted_index = b[IDX_W-1:0];
                    r.was_free = 1'b1;
                end
            end
            FUNC_RELEASE: begin
                if (it.block_index >= n_cap) begin
                    r.status = ST_RANGE;
                end else if (!used_mem[it.block_index]) begin
                    r.status = ST_BAD_REL;
                end else begin
                    used_mem[it.block_index] = 1'b0;
                    link_mem[it.block_index] = head_blk;
                    head_blk = {1'b0, it.block_index};
                    if (n_used > 0) n_used--;
                end
            end
            FUNC_CLAIM: begin
                if (it.block_index >= n_cap) begin
                    r.status = ST_RANGE;
                end else begin
                    r.granted_index = it.block_index;
                    if (!used_mem[it.block_index]) begin
                        prv = NIL;
                        cur = head_blk;
                        steps = 0;
                        while (cur < NIL && steps < MAX_BLOCKS) begin
                            if (cur == it.block_index) begin
                                if (prv == NIL) head_blk = link_mem[cur];
                                else link_mem[prv] = link_mem[cur];
                                link_mem[cur] = NIL;
                                break;
                            end
                            prv = cur;
                            cur = link_mem[cur];
                            steps++;
                        end
                        used_mem[it.block_index] = 1'b1;
                        n_used++;
                        r.was_free = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.in_use_count = n_used;
        r.capacity = n_cap;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                e = pending_q.pop_front();
                if (out_data.status != e.status)
                    report_mismatch("status", out_data.status, e.status);
                if (out_data.granted_index != e.granted_index)
                    report_mismatch("granted_index", out_data.granted_index, e.granted_index);
                if (out_data.was_free != e.was_free)
                    report_mismatch("was_free", out_data.was_free, e.was_free);
                if (out_data.in_use_count != e.in_use_count)
                    report_mismatch("in_use_count", out_data.in_use_count, e.in_use_count);
                if (out_data.capacity != e.capacity)
                    report_mismatch("capacity", out_data.capacity, e.capacity);
            end
        end
        // random stall bursts on the output, of random length
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_op(logic [1:0] f, logic [IDX_W-1:0] idx);
        t_in it;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        it.func = f;
        it.block_index = idx;
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        pending_q.push_back(predict_op(it));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_BLOCKS) begin
            start_reg = val;
            rebuild_pool();
        end else begin
            grow_reg = val[0];
        end
    endtask

    task automatic test_directed();
        send_op(FUNC_ALLOC, 10'h3FF);
        send_op(FUNC_ALLOC, 0);
        send_op(FUNC_CLAIM, 5);
        send_op(FUNC_CLAIM, 5);
        send_op(FUNC_CLAIM, 0);
        send_op(FUNC_CLAIM, 63);
        send_op(FUNC_CLAIM, 64);
        send_op(FUNC_CLAIM, 10'h3FF);
        send_op(FUNC_RELEASE, 5);
        send_op(FUNC_RELEASE, 5);
        send_op(FUNC_RELEASE, 64);
        send_op(FUNC_RELEASE, 10'h3FF);
        send_op(2'd3, 10'h2AA);
        send_op(FUNC_ALLOC, 0);
        send_op(FUNC_RELEASE, 0);
    endtask

    // exhaust a tiny pool, fail, then grow up to the ceiling
    task automatic test_growth();
        write_reg(CFG_START_BLOCKS, 0);
        write_reg(CFG_GROW_ON_FULL, 0);
        send_op(FUNC_ALLOC, 0);
        send_op(FUNC_ALLOC, 0);
        write_reg(CFG_GROW_ON_FULL, 1);
        for (int i = 0; i < 1030; i++) send_op(FUNC_ALLOC, 0);
        send_op(FUNC_RELEASE, 10'h3FF);
        send_op(FUNC_CLAIM, 10'h3FF);
        write_reg(CFG_START_BLOCKS, 11'h7FF);
        send_op(FUNC_CLAIM, 10'h3FF);
        send_op(FUNC_CLAIM, 512);
        send_op(FUNC_RELEASE, 512);
        write_reg(CFG_START_BLOCKS, 11'd1024);
        send_op(FUNC_ALLOC, 0);
        send_op(FUNC_RELEASE, 0);
    endtask

    task automatic run_random(int n, int sz, bit grow);
        logic [1:0] f;
        int top;
        write_reg(CFG_START_BLOCKS, sz[CFG_DATA_W-1:0]);
        write_reg(CFG_GROW_ON_FULL, CFG_DATA_W'(grow));
        for (int i = 0; i < n; i++) begin
            top = (n_cap > 1) ? n_cap - 1 : 1;
            case ($urandom_range(0, 9))
                0, 1, 2:    f = FUNC_ALLOC;
                3, 4, 5:    f = FUNC_RELEASE;
                6, 7, 8:    f = FUNC_CLAIM;
                default:    f = 2'd3;
            endcase
            if ($urandom_range(0, 7) == 0)
                send_op(f, IDX_W'($urandom_range(0, 1023)));
            else
                send_op(f, IDX_W'($urandom_range(0, top + 1)));
        end
    endtask

    initial begin
        start_reg = START_BLOCKS_RST;
        grow_reg  = 1'b0;
        rebuild_pool();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_growth();
        run_random(100, 8, 1'b0);
        run_random(100, 3, 1'b1);
        run_random(90, 40, 1'b0);
        run_random(80, 1, 1'b1);
        quiet = 1'b1;
        run_random(120, 17, 1'b1);
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_seq.sv
src/fixed_block_pool_allocator_core.sv
src/fbpa_checker.sv
bench/fixed_block_pool_allocator_core_tb.sv
